// ----- hdl/cptk_pkg.sv -----
// ----------------------------------------------------------------------------
// cptk_pkg
// Shared widths, register indexes and controller/datapath interface types of
// the correlation peak top-k picker.
// ----------------------------------------------------------------------------
`default_nettype none

package cptk_pkg;

	// Defaults for the top-level parameters
	localparam int PEAK_SLOTS_DEF   = 16;
	localparam int SURFACE_SIDE_DEF = 4096;

	// Hard cap on peaks reported per surface (rank field is 4 bits)
	localparam int MAX_REPORT = 16;

	// Field widths
	localparam int SCORE_W    = 32;
	localparam int OFS_W      = 12;
	localparam int LOC_W      = 32;
	localparam int HALF_W     = 12;
	localparam int MAXP_W     = 5;
	localparam int RANK_W     = 4;
	localparam int REP_W      = 5;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_PEAKS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_HALF_REF  = 3'd4;

	// Configuration reset values
	localparam logic signed [SCORE_W-1:0] THRESHOLD_RST = 32'sd45875;
	localparam logic [MAXP_W-1:0]         MAX_PEAKS_RST = 5'd1;

	// Commands from controller to datapath
	typedef struct packed {
		logic              in_ready;  // input channel may take a transaction
		logic              emit;      // load head of list into output register
		logic              found;     // emitted item carries a peak
		logic              final_pk;  // emitted item closes the surface
		logic [RANK_W-1:0] rank;      // rank of emitted item
		logic              clear;     // empty the peak list
	} cptk_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic             s1_valid;   // an item waits for insertion
		logic             s1_last;    // that item ends the surface
		logic             out_free;   // output register can be loaded
		logic [REP_W-1:0] rep_n;      // peaks to report for this surface
	} cptk_stat_t;

endpackage

`default_nettype wire

// ----- hdl/cptk_if.sv -----
// ----------------------------------------------------------------------------
// cptk_in_if / cptk_out_if
// Valid/ready channels for correlation scores and reported peaks.
// ----------------------------------------------------------------------------
`default_nettype none

interface cptk_in_if;
	import cptk_pkg::*;
	logic                      valid;
	logic                      ready;
	logic signed [SCORE_W-1:0] score;
	logic [OFS_W-1:0]          col_offset;
	logic [OFS_W-1:0]          row_offset;
	logic                      surface_end;

	modport source (output valid, score, col_offset, row_offset, surface_end,
		input ready);
	modport sink (input valid, score, col_offset, row_offset, surface_end,
		output ready);
endinterface

interface cptk_out_if;
	import cptk_pkg::*;
	logic                      valid;
	logic                      ready;
	logic                      found;
	logic signed [LOC_W-1:0]   peak_x;
	logic signed [LOC_W-1:0]   peak_y;
	logic signed [SCORE_W-1:0] peak_score;
	logic [RANK_W-1:0]         rank;
	logic                      final_peak;

	modport source (output valid, found, peak_x, peak_y, peak_score, rank,
		final_peak, input ready);
	modport sink (input valid, found, peak_x, peak_y, peak_score, rank,
		final_peak, output ready);
endinterface

`default_nettype wire

// ----- hdl/cptk_ctrl.sv -----
// ----------------------------------------------------------------------------
// cptk_ctrl
// Sequencer: streams scores into the datapath and, at the end of a surface,
// walks the report out one peak per output transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module cptk_ctrl
	import cptk_pkg::*;
(
	input  wire              clk,
	input  wire              arst_n,
	input  wire cptk_stat_t  stat,
	output cptk_cmd_t        cmd
);

	typedef enum logic {
		ST_STREAM,
		ST_REPORT
	} state_t;

	state_t            state_q;
	logic [RANK_W-1:0] k_q;
	logic              is_final;
	logic              is_empty;

	// Last report item: nothing kept, or rank plus one equals the report count
	always_comb begin
		is_empty = (stat.rep_n == '0);
		is_final = is_empty || ({1'b0, k_q} + REP_W'(1) == stat.rep_n);
	end

	always_comb begin
		cmd.in_ready = (state_q == ST_STREAM) && !(stat.s1_valid && stat.s1_last);
		cmd.emit     = (state_q == ST_REPORT) && stat.out_free;
		cmd.found    = !is_empty;
		cmd.final_pk = is_final;
		cmd.rank     = is_empty ? '0 : k_q;
		cmd.clear    = cmd.emit && is_final;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_STREAM;
			k_q     <= '0;
		end else begin
			unique case (state_q)
				ST_STREAM: begin
					// Closing score is inserted this cycle; report follows
					if (stat.s1_valid && stat.s1_last) begin
						state_q <= ST_REPORT;
						k_q     <= '0;
					end
				end
				ST_REPORT: begin
					if (stat.out_free) begin
						if (is_final) begin
							state_q <= ST_STREAM;
						end else begin
							k_q <= k_q + RANK_W'(1);
						end
					end
				end
				default: state_q <= ST_STREAM;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- hdl/cptk_dp.sv -----
// ----------------------------------------------------------------------------
// cptk_dp
// Datapath: configuration registers, input stage with location arithmetic,
// sorted peak list with parallel compare-and-shift insertion, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cptk_dp
	import cptk_pkg::*;
#(
	parameter int PEAK_SLOTS   = PEAK_SLOTS_DEF,
	parameter int SURFACE_SIDE = SURFACE_SIDE_DEF
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   cfg_we,
	input  wire [CFG_IDX_W-1:0]   cfg_index,
	input  wire [CFG_DATA_W-1:0]  cfg_data,
	cptk_in_if.sink               scores,
	cptk_out_if.source            peaks,
	input  wire cptk_cmd_t        cmd,
	output cptk_stat_t            stat
);

	localparam int CNT_W = $clog2(PEAK_SLOTS + 1);
	localparam int REP_CAP = (PEAK_SLOTS < MAX_REPORT) ? PEAK_SLOTS : MAX_REPORT;
	localparam logic [16:0] SIDE_MAX = 17'(SURFACE_SIDE - 1);

	// Configuration registers
	logic signed [SCORE_W-1:0] thr_q;
	logic [MAXP_W-1:0]         max_peaks_q;
	logic [LOC_W-1:0]          origin_x_q;
	logic [LOC_W-1:0]          origin_y_q;
	logic [HALF_W-1:0]         half_q;

	// Input stage
	logic                      s1_valid_q;
	logic                      s1_pass_s1;
	logic                      s1_last_s1;
	logic signed [SCORE_W-1:0] s1_score_s1;
	logic [LOC_W-1:0]          s1_x_s1;
	logic [LOC_W-1:0]          s1_y_s1;

	// Peak list, slot 0 is strongest
	logic signed [SCORE_W-1:0] ks_q [PEAK_SLOTS];
	logic [LOC_W-1:0]          kx_q [PEAK_SLOTS];
	logic [LOC_W-1:0]          ky_q [PEAK_SLOTS];
	logic [CNT_W-1:0]          count_q;
	logic [PEAK_SLOTS-1:0]     ge;
	logic                      insert;

	// Output register
	logic                      out_valid_q;
	logic                      out_found_q;
	logic [LOC_W-1:0]          out_x_q;
	logic [LOC_W-1:0]          out_y_q;
	logic signed [SCORE_W-1:0] out_score_q;
	logic [RANK_W-1:0]         out_rank_q;
	logic                      out_final_q;

	logic                      accept;
	logic [OFS_W-1:0]          col_c;
	logic [OFS_W-1:0]          row_c;
	logic [7:0]                lim;
	logic [7:0]                rep_full;

	function automatic logic [OFS_W-1:0] clamp_ofs(input logic [OFS_W-1:0] v);
		if ({5'd0, v} > SIDE_MAX) begin
			return SIDE_MAX[OFS_W-1:0];
		end
		return v;
	endfunction

	assign accept = scores.valid && scores.ready;
	assign scores.ready = cmd.in_ready;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q       <= THRESHOLD_RST;
			max_peaks_q <= MAX_PEAKS_RST;
			origin_x_q  <= '0;
			origin_y_q  <= '0;
			half_q      <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_THRESHOLD: thr_q       <= cfg_data;
				CFG_MAX_PEAKS: max_peaks_q <= cfg_data[MAXP_W-1:0];
				CFG_ORIGIN_X:  origin_x_q  <= cfg_data;
				CFG_ORIGIN_Y:  origin_y_q  <= cfg_data;
				CFG_HALF_REF:  half_q      <= cfg_data[HALF_W-1:0];
				default: ;
			endcase
		end
	end

	// Input stage: threshold test and view location
	always_comb begin
		col_c = clamp_ofs(scores.col_offset);
		row_c = clamp_ofs(scores.row_offset);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else begin
			s1_valid_q <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s1_pass_s1  <= (scores.score >= thr_q);
			s1_last_s1  <= scores.surface_end;
			s1_score_s1 <= scores.score;
			s1_x_s1     <= origin_x_q + LOC_W'(half_q) + LOC_W'(col_c);
			s1_y_s1     <= origin_y_q + LOC_W'(half_q) + LOC_W'(row_c);
		end
	end

	// Slots holding a score at or above the new one (a prefix of the list)
	always_comb begin
		for (int i = 0; i < PEAK_SLOTS; i++) begin
			ge[i] = (CNT_W'(i) < count_q) && (ks_q[i] >= s1_score_s1);
		end
		insert = s1_valid_q && s1_pass_s1;
	end

	// List update: insert with shift, or pop the head while reporting
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			for (int i = 0; i < PEAK_SLOTS - 1; i++) begin
				ks_q[i] <= ks_q[i+1];
				kx_q[i] <= kx_q[i+1];
				ky_q[i] <= ky_q[i+1];
			end
		end else if (insert) begin
			if (!ge[0]) begin
				ks_q[0] <= s1_score_s1;
				kx_q[0] <= s1_x_s1;
				ky_q[0] <= s1_y_s1;
			end
			for (int i = 1; i < PEAK_SLOTS; i++) begin
				if (!ge[i]) begin
					if (ge[i-1]) begin
						ks_q[i] <= s1_score_s1;
						kx_q[i] <= s1_x_s1;
						ky_q[i] <= s1_y_s1;
					end else begin
						ks_q[i] <= ks_q[i-1];
						kx_q[i] <= kx_q[i-1];
						ky_q[i] <= ky_q[i-1];
					end
				end
			end
		end
	end

	// Fill count; reporting pops do not change it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.clear) begin
			count_q <= '0;
		end else if (insert && (count_q < CNT_W'(PEAK_SLOTS))) begin
			count_q <= count_q + CNT_W'(1);
		end
	end

	// Report count: max_peaks limited by capacity, cap and fill
	always_comb begin
		lim      = ({3'd0, max_peaks_q} < 8'(REP_CAP)) ? {3'd0, max_peaks_q} : 8'(REP_CAP);
		rep_full = (8'(count_q) < lim) ? 8'(count_q) : lim;
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (peaks.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_found_q <= cmd.found;
			out_x_q     <= cmd.found ? kx_q[0] : '0;
			out_y_q     <= cmd.found ? ky_q[0] : '0;
			out_score_q <= cmd.found ? ks_q[0] : '0;
			out_rank_q  <= cmd.rank;
			out_final_q <= cmd.final_pk;
		end
	end

	assign peaks.valid      = out_valid_q;
	assign peaks.found      = out_found_q;
	assign peaks.peak_x     = out_x_q;
	assign peaks.peak_y     = out_y_q;
	assign peaks.peak_score = out_score_q;
	assign peaks.rank       = out_rank_q;
	assign peaks.final_peak = out_final_q;

	always_comb begin
		stat.s1_valid = s1_valid_q;
		stat.s1_last  = s1_last_s1;
		stat.out_free = !out_valid_q || peaks.ready;
		stat.rep_n    = rep_full[REP_W-1:0];
	end

endmodule

`default_nettype wire

// ----- hdl/correlation_peak_top_k_picker_unit.sv -----
// A score is registered in the input stage and then inserted into the peak list; the
// closing score is inserted before the first report item enters the output register.
// Throughput: one score per cycle within a surface; input ready drops while the
// closing score is inserted and while n peaks leave, one per cycle (output permitting).
// Reset: asynchronous, active low; empties the list and restores register defaults.
// ----------------------------------------------------------------------------
// correlation_peak_top_k_picker_unit
// Keeps the strongest thresholded correlation peaks of a surface in a sorted
// list and reports them, strongest first, when the surface ends.
// ----------------------------------------------------------------------------
`default_nettype none

module correlation_peak_top_k_picker_unit
	import cptk_pkg::*;
#(
	parameter int PEAK_SLOTS   = PEAK_SLOTS_DEF,
	parameter int SURFACE_SIDE = SURFACE_SIDE_DEF
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  cfg_we,
	input  wire [CFG_IDX_W-1:0]  cfg_index,
	input  wire [CFG_DATA_W-1:0] cfg_data,
	cptk_in_if.sink              scores,
	cptk_out_if.source           peaks
);

	cptk_cmd_t  cmd;
	cptk_stat_t stat;

	cptk_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.cmd    (cmd)
	);

	cptk_dp #(
		.PEAK_SLOTS   (PEAK_SLOTS),
		.SURFACE_SIDE (SURFACE_SIDE)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.scores    (scores),
		.peaks     (peaks),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule

`default_nettype wire

// ----- verif/tb_correlation_peak_top_k_picker_unit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_correlation_peak_top_k_picker_unit
// Streams scored correlation surfaces into the peak picker and checks every
// reported peak against a local top-k list model. A few hand-built surfaces
// cover the threshold edge, score extremes, location wrap, ties and a full
// list. Random surfaces follow over several register settings, with random
// stalls on both channels and one long output hold-off that backs up the input.
// ----------------------------------------------------------------------------

module tb_correlation_peak_top_k_picker_unit;
	import cptk_pkg::*;

	localparam int LIMIT_CYCLES  = 200000;
	localparam int SETTLE_CYCLES = 8;
	localparam int LONG_HOLD     = 80;
	localparam int PHASES        = 8;
	localparam int PHASE_ITEMS   = 37;

	localparam logic signed [SCORE_W-1:0] SCORE_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [SCORE_W-1:0] SCORE_MIN = 32'sh8000_0000;
	localparam logic [OFS_W-1:0]          OFS_MAX   = '1;

	// One reported peak as seen on the output channel
	typedef struct {
		logic                      found;
		logic signed [LOC_W-1:0]   x;
		logic signed [LOC_W-1:0]   y;
		logic signed [SCORE_W-1:0] score;
		logic [RANK_W-1:0]         rank;
		logic                      final_peak;
	} peak_t;

	// One entry of the sorted peak list
	typedef struct {
		logic signed [SCORE_W-1:0] score;
		logic [LOC_W-1:0]          x;
		logic [LOC_W-1:0]          y;
	} kept_peak_t;

	// Top-k list model plus the queue of peaks still due on the output
	class peak_board;
		logic signed [SCORE_W-1:0] threshold;
		logic [MAXP_W-1:0]         max_peaks;
		logic [LOC_W-1:0]          origin_x;
		logic [LOC_W-1:0]          origin_y;
		logic [HALF_W-1:0]         half_ref;
		kept_peak_t                kept[$];
		peak_t                     expected[$];
		int                        errors;

		function new();
			threshold = THRESHOLD_RST;
			max_peaks = MAX_PEAKS_RST;
			origin_x  = '0;
			origin_y  = '0;
			half_ref  = '0;
			errors    = 0;
		endfunction

		function void set_config(logic [CFG_DATA_W-1:0] thr, logic [CFG_DATA_W-1:0] maxp,
			logic [CFG_DATA_W-1:0] ox, logic [CFG_DATA_W-1:0] oy,
			logic [CFG_DATA_W-1:0] half);
			threshold = thr;
			max_peaks = maxp[MAXP_W-1:0];
			origin_x  = ox;
			origin_y  = oy;
			half_ref  = half[HALF_W-1:0];
		endfunction

		function int pending();
			return expected.size();
		endfunction

		// Insert a score in strength order; a closing score queues the report
		function void note_score(logic signed [SCORE_W-1:0] s, logic [OFS_W-1:0] col,
			logic [OFS_W-1:0] row, logic last);
			kept_peak_t pk;
			peak_t      res;
			int         pos;
			int         n;
			if (s >= threshold) begin
				pk.score = s;
				pk.x     = origin_x + LOC_W'(half_ref) + LOC_W'(col);
				pk.y     = origin_y + LOC_W'(half_ref) + LOC_W'(row);
				// ties keep arrival order: skip past equal scores
				pos = 0;
				while (pos < kept.size() && kept[pos].score >= s)
					pos++;
				if (pos < PEAK_SLOTS_DEF) begin
					kept.insert(pos, pk);
					if (kept.size() > PEAK_SLOTS_DEF)
						void'(kept.pop_back());
				end
			end
			if (!last)
				return;
			n = max_peaks;
			if (n > PEAK_SLOTS_DEF)
				n = PEAK_SLOTS_DEF;
			if (n > MAX_REPORT)
				n = MAX_REPORT;
			if (n > kept.size())
				n = kept.size();
			if (n == 0) begin
				res.found      = 1'b0;
				res.x          = '0;
				res.y          = '0;
				res.score      = '0;
				res.rank       = '0;
				res.final_peak = 1'b1;
				expected.insert(expected.size(), res);
			end
			for (int k = 0; k < n; k++) begin
				res.found      = 1'b1;
				res.x          = kept[k].x;
				res.y          = kept[k].y;
				res.score      = kept[k].score;
				res.rank       = RANK_W'(k);
				res.final_peak = (k == n - 1);
				expected.insert(expected.size(), res);
			end
			kept.delete();
		endfunction

		function void compare_field(string field, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
				errors++;
			end
		endfunction

		// Compare one output transaction with the oldest outstanding peak
		function void check_peak(peak_t got);
			peak_t want;
			if (expected.size() == 0) begin
				$display("%0t: unexpected peak, expected none, actual score %0h rank %0d",
					$time, got.score, got.rank);
				errors++;
				return;
			end
			want = expected.pop_front();
			compare_field("found", want.found, got.found);
			compare_field("peak_x", want.x, got.x);
			compare_field("peak_y", want.y, got.y);
			compare_field("peak_score", want.score, got.score);
			compare_field("rank", want.rank, got.rank);
			compare_field("final_peak", want.final_peak, got.final_peak);
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  quiet    = 1'b0;
	logic                  hold_req = 1'b0;
	int                    cycle_cnt = 0;
	peak_board             board = new();

	cptk_in_if  score_if();
	cptk_out_if peak_if();

	correlation_peak_top_k_picker_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.scores    (score_if),
		.peaks     (peak_if)
	);

	// Clock and run limit
	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

	initial begin
		wait (cycle_cnt >= LIMIT_CYCLES);
		$display("Mismatches found");
		$finish;
	end

	// Output side: check accepted peaks, then pick ready for the next cycle
	initial begin
		peak_t got;
		int    hold_left;
		logic  hold_done;
		hold_left     = 0;
		hold_done     = 1'b0;
		peak_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (peak_if.valid && peak_if.ready) begin
				got.found      = peak_if.found;
				got.x          = peak_if.peak_x;
				got.y          = peak_if.peak_y;
				got.score      = peak_if.peak_score;
				got.rank       = peak_if.rank;
				got.final_peak = peak_if.final_peak;
				board.check_peak(got);
			end
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				hold_left = LONG_HOLD;
			end else if (hold_left == 0 && !quiet && $urandom_range(0, 4) == 0) begin
				hold_left = $urandom_range(1, 3);
			end
			if (hold_left > 0) begin
				hold_left--;
				peak_if.ready <= 1'b0;
			end else begin
				peak_if.ready <= 1'b1;
			end
		end
	end

	// Offer one score, with an occasional gap first, and wait for the transaction
	task automatic send_score(logic signed [SCORE_W-1:0] s, logic [OFS_W-1:0] col,
		logic [OFS_W-1:0] row, logic last);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			score_if.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		score_if.valid       <= 1'b1;
		score_if.score       <= s;
		score_if.col_offset  <= col;
		score_if.row_offset  <= row;
		score_if.surface_end <= last;
		do @(posedge clk); while (!score_if.ready);
		board.note_score(s, col, row, last);
	endtask

	// Drop valid and let every outstanding report drain
	task automatic settle();
		score_if.valid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write all five registers back to back
	task automatic apply_config(logic [CFG_DATA_W-1:0] thr, logic [CFG_DATA_W-1:0] maxp,
		logic [CFG_DATA_W-1:0] ox, logic [CFG_DATA_W-1:0] oy, logic [CFG_DATA_W-1:0] half);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_THRESHOLD;
		cfg_data  <= thr;
		@(posedge clk);
		cfg_index <= CFG_MAX_PEAKS;
		cfg_data  <= maxp;
		@(posedge clk);
		cfg_index <= CFG_ORIGIN_X;
		cfg_data  <= ox;
		@(posedge clk);
		cfg_index <= CFG_ORIGIN_Y;
		cfg_data  <= oy;
		@(posedge clk);
		cfg_index <= CFG_HALF_REF;
		cfg_data  <= half;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.set_config(thr, maxp, ox, oy, half);
	endtask

	// Scores cluster around the threshold to get ties and edge hits
	function automatic logic signed [SCORE_W-1:0] pick_score(logic signed [SCORE_W-1:0] thr);
		longint v;
		case ($urandom_range(0, 9))
			0, 1, 2: begin
				v = longint'(thr) + longint'($urandom_range(0, 6)) - 3;
				if (v > longint'(SCORE_MAX))
					v = SCORE_MAX;
				if (v < longint'(SCORE_MIN))
					v = SCORE_MIN;
			end
			3: v = $urandom_range(0, 1) ? SCORE_MAX : SCORE_MIN;
			default: v = $urandom;
		endcase
		return v[SCORE_W-1:0];
	endfunction

	function automatic logic [OFS_W-1:0] pick_offset();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(0, 1) ? OFS_MAX : {OFS_W{1'b0}};
		return OFS_W'($urandom_range(0, (1 << OFS_W) - 1));
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_threshold();
		if ($urandom_range(0, 3) == 0)
			return $urandom;
		return $urandom_range(0, 400000) - 200000;
	endfunction

	// Reset, directed surfaces, then random phases
	initial begin
		int                    taken;
		int                    len;
		logic [CFG_DATA_W-1:0] thr;
		arst_n               = 1'b0;
		cfg_we               = 1'b0;
		cfg_index            = CFG_THRESHOLD;
		cfg_data             = '0;
		score_if.valid       = 1'b0;
		score_if.score       = '0;
		score_if.col_offset  = '0;
		score_if.row_offset  = '0;
		score_if.surface_end = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// just under the threshold: not-found report
		send_score(THRESHOLD_RST - 1, 12'd0, 12'd0, 1'b1);
		// exactly at the threshold is kept; one peak reported after reset
		send_score(THRESHOLD_RST, OFS_MAX, OFS_MAX, 1'b0);
		send_score(32'sd0, 12'd5, 12'd9, 1'b1);
		settle();

		// score extremes, wrapping locations, equal scores in arrival order
		apply_config(SCORE_MIN, 32'd16, 32'h7FFF_FFFF, 32'h8000_0000, 32'd4095);
		send_score(SCORE_MAX, OFS_MAX, 12'd0, 1'b0);
		send_score(SCORE_MIN, 12'd0, OFS_MAX, 1'b0);
		send_score(32'sd5, 12'd1, 12'd2, 1'b0);
		send_score(32'sd5, 12'd3, 12'd4, 1'b1);

		// full list: a tie with the weakest is dropped, a stronger one evicts it
		for (int i = 0; i < PEAK_SLOTS_DEF; i++)
			send_score(32'(1600 - 100 * i), 12'(i), 12'(2 * i), 1'b0);
		send_score(32'sd100, 12'd77, 12'd78, 1'b0);
		send_score(32'sd150, 12'd88, 12'd99, 1'b1);

		// random surfaces, one register setting per phase
		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			case (ph)
				0: apply_config(SCORE_MIN, 32'd16, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd4095);
				1: apply_config(SCORE_MAX, 32'd31, 32'h8000_0000, 32'h8000_0000, 32'd0);
				2: apply_config(pick_threshold(), 32'd16, $urandom, $urandom, 32'd2048);
				3: apply_config(pick_threshold(), 32'd0, $urandom, $urandom,
					$urandom_range(0, 4095));
				default: apply_config(pick_threshold(), $urandom_range(0, 16), $urandom,
					$urandom, $urandom_range(0, 4095));
			endcase
			thr = board.threshold;
			// long output hold-off so the input backs up behind the report
			if (ph == 2)
				hold_req = 1'b1;
			// last phase runs without gaps or stalls
			if (ph == PHASES - 1)
				quiet = 1'b1;
			taken = 0;
			while (taken < PHASE_ITEMS) begin
				len = ($urandom_range(0, 4) == 0) ? $urandom_range(17, 24) : $urandom_range(1, 8);
				for (int i = 0; i < len; i++)
					send_score(pick_score(thr), pick_offset(), pick_offset(), i == len - 1);
				taken += len;
			end
		end
		settle();

		if (board.errors == 0 && board.pending() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
